/* rtl/rtpx_pkg.sv */
// rtpx_pkg: shared constants, register codes and types of the rtp extension packetizer
// no dependencies; used by rtpx_cfg_if and all rtl modules

package rtpx_pkg;

  // packet geometry
  localparam int MAX_PACKET_BYTES = 1500;
  localparam int HDR_BYTES        = 20;
  localparam int HDR_IDX_W        = $clog2(HDR_BYTES + 1);
  localparam int LEN_W            = 11;
  localparam int CAP_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [CAP_W-1:0] PAYLOAD_CAP = CAP_W'(MAX_PACKET_BYTES - HDR_BYTES);

  // first header byte: version 2, extension bit set
  localparam logic [7:0] VER_BYTE = 8'h90;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_ID       = 3'd0,
    REG_STREAM_NUMBER   = 3'd1,
    REG_PAYLOAD_TYPE    = 3'd2,
    REG_TIMESTAMP_STEP  = 3'd3,
    REG_MEDIA_TIME_STEP = 3'd4,
    REG_PAYLOAD_LENGTH  = 3'd5
  } cfg_reg_t;

  // register reset values
  localparam logic [31:0]      SOURCE_ID_RST       = 32'd0;
  localparam logic [15:0]      STREAM_NUMBER_RST   = 16'd1;
  localparam logic [6:0]       PAYLOAD_TYPE_RST    = 7'd96;
  localparam logic [15:0]      TIMESTAMP_STEP_RST  = 16'd64;
  localparam logic [31:0]      MEDIA_TIME_STEP_RST = 32'd1333333;
  localparam logic [LEN_W-1:0] PAYLOAD_LENGTH_RST  = LEN_W'(512);

  // register file contents as seen by the framer
  typedef struct packed {
    logic [31:0]      source_id;
    logic [15:0]      stream_number;
    logic [6:0]       payload_type;
    logic [15:0]      timestamp_step;
    logic [31:0]      media_time_step;
    logic [LEN_W-1:0] payload_length;
  } cfg_t;

endpackage

/* rtl/rtpx_byte_if.sv */
// rtpx_byte_if: valid/ready channel carrying one payload byte per transfer
// depends on nothing

interface rtpx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink   (input valid, input payload_byte, output ready);
endinterface

/* rtl/rtpx_pkt_if.sv */
// rtpx_pkt_if: valid/ready channel carrying one packet byte and its flags per transfer
// depends on nothing

interface rtpx_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_start;
  logic       packet_end;
  logic       run_last;

  modport source (output valid, output packet_byte, output packet_start,
                  output packet_end, output run_last, input ready);
  modport sink   (input valid, input packet_byte, input packet_start,
                  input packet_end, input run_last, output ready);
endinterface

/* rtl/rtpx_cfg_if.sv */
// rtpx_cfg_if: configuration write channel with register index and write data
// depends on rtpx_pkg for widths

interface rtpx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rtpx_pkg::CFG_IDX_W-1:0]   index;
  logic [rtpx_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/rtpx_cfg_regs.sv */
// rtpx_cfg_regs: configuration register file of the packetizer
// depends on rtpx_pkg and rtpx_cfg_if

module rtpx_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  rtpx_cfg_if.sink          cfg_wr,
  output rtpx_pkg::cfg_t    cfg
);

  // writes are always taken
  assign cfg_wr.ready = 1'b1;

  // register decode and update, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_id       <= rtpx_pkg::SOURCE_ID_RST;
      cfg.stream_number   <= rtpx_pkg::STREAM_NUMBER_RST;
      cfg.payload_type    <= rtpx_pkg::PAYLOAD_TYPE_RST;
      cfg.timestamp_step  <= rtpx_pkg::TIMESTAMP_STEP_RST;
      cfg.media_time_step <= rtpx_pkg::MEDIA_TIME_STEP_RST;
      cfg.payload_length  <= rtpx_pkg::PAYLOAD_LENGTH_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        rtpx_pkg::REG_SOURCE_ID:       cfg.source_id       <= cfg_wr.data;
        rtpx_pkg::REG_STREAM_NUMBER:   cfg.stream_number   <= cfg_wr.data[15:0];
        rtpx_pkg::REG_PAYLOAD_TYPE:    cfg.payload_type    <= cfg_wr.data[6:0];
        rtpx_pkg::REG_TIMESTAMP_STEP:  cfg.timestamp_step  <= cfg_wr.data[15:0];
        rtpx_pkg::REG_MEDIA_TIME_STEP: cfg.media_time_step <= cfg_wr.data;
        rtpx_pkg::REG_PAYLOAD_LENGTH:
          cfg.payload_length <= cfg_wr.data[rtpx_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/rtpx_framer.sv */
// rtpx_framer: input holding register, header/payload byte selection, packet counters
// and output register; depends on rtpx_pkg, rtpx_byte_if and rtpx_pkt_if

module rtpx_framer (
  input  logic              clk,
  input  logic              rst,
  input  rtpx_pkg::cfg_t    cfg,
  rtpx_byte_if.sink         payload_in,
  rtpx_pkt_if.source        packet_out
);

  // holding register for the accepted payload byte
  logic       held_valid;
  logic [7:0] held_byte;

  // packet state
  logic [15:0]                     sequence_low;
  logic [15:0]                     sequence_high;
  logic [31:0]                     rtp_timestamp;
  logic [31:0]                     media_time;
  logic [rtpx_pkg::LEN_W-1:0]      bytes_in_packet;
  logic [rtpx_pkg::HDR_IDX_W-1:0]  hdr_idx;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_start;
  logic       out_end;
  logic       out_last;

  logic                            emit;
  logic                            payload_phase;
  logic                            consume;
  logic [rtpx_pkg::CAP_W-1:0]      eff_len;
  logic [rtpx_pkg::CAP_W-1:0]      sent_plus_one;
  logic                            pkt_done;
  logic [7:0]                      hdr_byte;
  logic [15:0]                     seq_low_next;

  // a byte leaves whenever one is held and the output register is free
  assign emit          = held_valid && (!out_valid || packet_out.ready);
  assign payload_phase = (bytes_in_packet != '0) ||
                         (hdr_idx == rtpx_pkg::HDR_IDX_W'(rtpx_pkg::HDR_BYTES));
  assign consume       = emit && payload_phase;
  assign payload_in.ready = !held_valid || consume;

  // effective payload length: zero counts as one, clamp to what fits beside the header
  always_comb begin
    eff_len = rtpx_pkg::CAP_W'(cfg.payload_length);
    if (cfg.payload_length == '0) begin
      eff_len = rtpx_pkg::CAP_W'(1);
    end
    if (eff_len > rtpx_pkg::PAYLOAD_CAP) begin
      eff_len = rtpx_pkg::PAYLOAD_CAP;
    end
  end

  assign sent_plus_one = rtpx_pkg::CAP_W'(bytes_in_packet) + rtpx_pkg::CAP_W'(1);
  assign pkt_done      = (sent_plus_one >= eff_len);
  assign seq_low_next  = sequence_low + 16'd1;

  // header byte select
  always_comb begin
    case (hdr_idx)
      5'd0:    hdr_byte = rtpx_pkg::VER_BYTE;
      5'd1:    hdr_byte = {1'b0, cfg.payload_type};
      5'd2:    hdr_byte = sequence_low[15:8];
      5'd3:    hdr_byte = sequence_low[7:0];
      5'd4:    hdr_byte = rtp_timestamp[31:24];
      5'd5:    hdr_byte = rtp_timestamp[23:16];
      5'd6:    hdr_byte = rtp_timestamp[15:8];
      5'd7:    hdr_byte = rtp_timestamp[7:0];
      5'd8:    hdr_byte = cfg.source_id[31:24];
      5'd9:    hdr_byte = cfg.source_id[23:16];
      5'd10:   hdr_byte = cfg.source_id[15:8];
      5'd11:   hdr_byte = cfg.source_id[7:0];
      5'd12:   hdr_byte = cfg.stream_number[15:8];
      5'd13:   hdr_byte = cfg.stream_number[7:0];
      5'd14:   hdr_byte = sequence_high[15:8];
      5'd15:   hdr_byte = sequence_high[7:0];
      5'd16:   hdr_byte = media_time[31:24];
      5'd17:   hdr_byte = media_time[23:16];
      5'd18:   hdr_byte = media_time[15:8];
      5'd19:   hdr_byte = media_time[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (payload_in.ready) begin
      held_valid <= payload_in.valid;
    end
    if (payload_in.valid && payload_in.ready) begin
      held_byte <= payload_in.payload_byte;
    end
  end

  // header index and packet counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx         <= '0;
      bytes_in_packet <= '0;
      sequence_low    <= '0;
      sequence_high   <= '0;
      rtp_timestamp   <= '0;
      media_time      <= '0;
    end else if (emit) begin
      if (!payload_phase) begin
        hdr_idx <= hdr_idx + rtpx_pkg::HDR_IDX_W'(1);
      end else begin
        hdr_idx <= '0;
        if (pkt_done) begin
          bytes_in_packet <= '0;
          sequence_low    <= seq_low_next;
          if (seq_low_next == 16'd0) begin
            sequence_high <= sequence_high + 16'd1;
          end
          rtp_timestamp <= rtp_timestamp + {16'd0, cfg.timestamp_step};
          media_time    <= media_time + cfg.media_time_step;
        end else begin
          bytes_in_packet <= bytes_in_packet + rtpx_pkg::LEN_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (packet_out.ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_byte  <= payload_phase ? held_byte : hdr_byte;
      out_start <= !payload_phase && (hdr_idx == '0);
      out_end   <= payload_phase && pkt_done;
      out_last  <= payload_phase;
    end
  end

  assign packet_out.valid        = out_valid;
  assign packet_out.packet_byte  = out_byte;
  assign packet_out.packet_start = out_start;
  assign packet_out.packet_end   = out_end;
  assign packet_out.run_last     = out_last;

endmodule

/* rtl/rtp_ext_packetizer_unit.sv */
// rtp_ext_packetizer_unit: one payload byte per transfer in, packet bytes out.
// Path: a payload byte passes the holding register, then the output register;
// the first byte of a packet follows 20 header bytes, one per cycle without stalls.
// Throughput: one output byte per cycle while packet_out.ready holds, set by the
// single output register; input likewise, but waits while the 20 header bytes go out.
// Reset (rst, synchronous): registers to defaults, counters to zero, channels empty.

module rtp_ext_packetizer_unit (
  input  logic         clk,
  input  logic         rst,
  rtpx_cfg_if.sink     cfg_wr,
  rtpx_byte_if.sink    payload_in,
  rtpx_pkt_if.source   packet_out
);

  rtpx_pkg::cfg_t cfg;

  // configuration registers
  rtpx_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // header insertion and payload pass-through
  rtpx_framer u_framer (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .payload_in (payload_in),
    .packet_out (packet_out)
  );

endmodule

/* dv/rtpx_framing_check.sv */
// rtpx_framing_check: predicts the packet byte stream of rtp_ext_packetizer_unit and compares it
// watches the config, payload and packet channels; depends on rtpx_pkg and the rtpx_*_if interfaces

module rtpx_framing_check
  import rtpx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rtpx_cfg_if  cfg_wr,
  rtpx_byte_if payload_in,
  rtpx_pkt_if  packet_out,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sop;
    logic       eop;
    logic       run_end;
  } pkt_beat_t;

  // shadow of the register file and the packet counters
  cfg_t        cfg_now;
  logic [15:0] seq_lo;
  logic [15:0] seq_hi;
  logic [31:0] ts_now;
  logic [31:0] mtime_now;
  int unsigned fill_count;

  pkt_beat_t   awaited_beats[$];
  int          mismatches = 0;

  // turn one accepted payload byte into the packet bytes it releases
  task automatic frame_payload_byte(input logic [7:0] data);
    logic [159:0] hdr;
    int unsigned  len;
    int           i;
    pkt_beat_t    beat;
    logic         closes;
    // zero length acts as one, oversize clamps to what fits beside the header
    len = cfg_now.payload_length;
    if (len == 0) len = 1;
    if (len > PAYLOAD_CAP) len = PAYLOAD_CAP;
    // opening byte of a packet releases header and extension first
    if (fill_count == 0) begin
      hdr = {VER_BYTE, 1'b0, cfg_now.payload_type, seq_lo, ts_now, cfg_now.source_id,
             cfg_now.stream_number, seq_hi, mtime_now};
      for (i = 0; i < HDR_BYTES; i++) begin
        beat.data_byte = hdr[159 - 8*i -: 8];
        beat.sop       = (i == 0);
        beat.eop       = 1'b0;
        beat.run_end   = 1'b0;
        awaited_beats.push_back(beat);
      end
    end
    closes = (fill_count + 1 >= len);
    beat.data_byte = data;
    beat.sop       = 1'b0;
    beat.eop       = closes;
    beat.run_end   = 1'b1;
    awaited_beats.push_back(beat);
    // counters advance once the packet is closed
    if (closes) begin
      fill_count = 0;
      seq_lo = seq_lo + 16'd1;
      if (seq_lo == 16'd0) seq_hi = seq_hi + 16'd1;
      ts_now    = ts_now + 32'(cfg_now.timestamp_step);
      mtime_now = mtime_now + cfg_now.media_time_step;
    end else begin
      fill_count = fill_count + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    pkt_beat_t want;
    pkt_beat_t got;
    if (rst) begin
      cfg_now.source_id       = SOURCE_ID_RST;
      cfg_now.stream_number   = STREAM_NUMBER_RST;
      cfg_now.payload_type    = PAYLOAD_TYPE_RST;
      cfg_now.timestamp_step  = TIMESTAMP_STEP_RST;
      cfg_now.media_time_step = MEDIA_TIME_STEP_RST;
      cfg_now.payload_length  = PAYLOAD_LENGTH_RST;
      seq_lo     = '0;
      seq_hi     = '0;
      ts_now     = '0;
      mtime_now  = '0;
      fill_count = 0;
      awaited_beats.delete();
    end else begin
      // register writes, unmapped indexes are dropped
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_reg_t'(cfg_wr.index))
          REG_SOURCE_ID:       cfg_now.source_id       = cfg_wr.data;
          REG_STREAM_NUMBER:   cfg_now.stream_number   = cfg_wr.data[15:0];
          REG_PAYLOAD_TYPE:    cfg_now.payload_type    = cfg_wr.data[6:0];
          REG_TIMESTAMP_STEP:  cfg_now.timestamp_step  = cfg_wr.data[15:0];
          REG_MEDIA_TIME_STEP: cfg_now.media_time_step = cfg_wr.data;
          REG_PAYLOAD_LENGTH:  cfg_now.payload_length  = cfg_wr.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (payload_in.valid && payload_in.ready) frame_payload_byte(payload_in.payload_byte);
      // compare each outgoing transfer with the oldest prediction
      if (packet_out.valid && packet_out.ready) begin
        got.data_byte = packet_out.packet_byte;
        got.sop       = packet_out.packet_start;
        got.eop       = packet_out.packet_end;
        got.run_end   = packet_out.run_last;
        if (awaited_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected packet byte %02h start %0b end %0b last %0b", $time,
                     got.data_byte, got.sop, got.eop, got.run_end);
        end else begin
          want = awaited_beats.pop_front();
          if (got.data_byte !== want.data_byte || got.sop !== want.sop ||
              got.eop !== want.eop || got.run_end !== want.run_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: packet byte mismatch exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                       $time, want.data_byte, want.sop, want.eop, want.run_end,
                       got.data_byte, got.sop, got.eop, got.run_end);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= awaited_beats.size();
  end

endmodule

/* dv/tb_rtp_ext_packetizer_unit.sv */
// tb_rtp_ext_packetizer_unit: stimulus and verdict for rtp_ext_packetizer_unit
// depends on rtpx_pkg, the rtpx_*_if interfaces and rtpx_framing_check

module tb_rtp_ext_packetizer_unit;
  import rtpx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_B = 3'd7;
  localparam int RANDOM_ITEMS = 330;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_beats;
  bit   sender_steady;
  int   burst_left;
  int   sink_mode;
  int   stall_left;
  int   sink_tick;

  rtpx_cfg_if  cfg_ch ();
  rtpx_byte_if byte_ch ();
  rtpx_pkt_if  pkt_ch ();

  rtp_ext_packetizer_unit dut (
    .clk,
    .rst,
    .cfg_wr     (cfg_ch),
    .payload_in (byte_ch),
    .packet_out (pkt_ch)
  );

  rtpx_framing_check framing_check (
    .clk,
    .rst,
    .cfg_wr     (cfg_ch),
    .payload_in (byte_ch),
    .packet_out (pkt_ch),
    .fail_count,
    .pending    (pending_beats)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: free, light or heavy stalling, in a randomly picked mode
  always @(posedge clk) begin
    if (rst) begin
      pkt_ch.ready <= 1'b0;
      stall_left   <= 0;
      sink_tick    <= 0;
      sink_mode    <= 0;
    end else begin
      sink_tick <= sink_tick + 1;
      if (sink_tick % 200 == 0) sink_mode <= $urandom_range(0, 2);
      if (stall_left != 0) begin
        pkt_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (sink_mode == 0) begin
        pkt_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 7) < sink_mode * 2) begin
        pkt_ch.ready <= 1'b0;
        stall_left   <= $urandom_range(0, 11);
      end else begin
        pkt_ch.ready <= 1'b1;
      end
    end
  end

  // register write, valid stays up between back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // one payload transfer, with a random gap between bursts
  task automatic send_byte(input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    byte_ch.valid        <= 1'b1;
    byte_ch.payload_byte <= value;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // hold the sender until every predicted byte has left
  task automatic drain();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  initial begin
    int          items;
    int          n;
    logic [10:0] len;
    byte_ch.valid        <= 1'b0;
    byte_ch.payload_byte <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_SOURCE_ID;
    cfg_ch.data          <= '0;
    rst                  <= 1'b1;
    sender_steady = 1'b0;
    burst_left    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: open a packet, then shrink the length mid-packet
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    drain();
    write_reg(REG_PAYLOAD_LENGTH, 32'd0);
    cfg_ch.valid <= 1'b0;
    send_byte(8'hA5);
    // zero length means one byte per packet
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();

    // all-ones settings, wide write data gets masked
    write_reg(REG_SOURCE_ID, 32'hFFFF_FFFF);
    write_reg(REG_STREAM_NUMBER, 32'hFFFF_FFFF);
    write_reg(REG_PAYLOAD_TYPE, 32'hFFFF_FFFF);
    write_reg(REG_TIMESTAMP_STEP, 32'hFFFF_FFFF);
    write_reg(REG_MEDIA_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(REG_PAYLOAD_LENGTH, 32'hFFFF_F802);
    cfg_ch.valid <= 1'b0;
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h55);
    drain();

    // unmapped indexes must leave the settings alone
    write_reg(UNMAPPED_IDX_A, $urandom);
    write_reg(UNMAPPED_IDX_B, $urandom);
    cfg_ch.valid <= 1'b0;
    send_byte(8'h0F);
    send_byte(8'hF0);
    drain();

    // all-zero settings, except a payload length of one
    write_reg(REG_SOURCE_ID, 32'd0);
    write_reg(REG_STREAM_NUMBER, 32'd0);
    write_reg(REG_PAYLOAD_TYPE, 32'd0);
    write_reg(REG_TIMESTAMP_STEP, 32'd0);
    write_reg(REG_MEDIA_TIME_STEP, 32'd0);
    write_reg(REG_PAYLOAD_LENGTH, 32'd1);
    cfg_ch.valid <= 1'b0;
    send_byte(8'h81);
    send_byte(8'h7E);
    drain();

    // random phases, settings change only while the output is empty
    items = 0;
    while (items < RANDOM_ITEMS) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(REG_SOURCE_ID, $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_STREAM_NUMBER, $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_PAYLOAD_TYPE, $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_TIMESTAMP_STEP, $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_MEDIA_TIME_STEP, $urandom);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: len = 11'd0;
          1: len = 11'($urandom_range(1, 4));
          2: len = 11'($urandom_range(5, 40));
          default: len = 11'($urandom_range(41, 120));
        endcase
        write_reg(REG_PAYLOAD_LENGTH, {21'($urandom), len});
      end
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? UNMAPPED_IDX_A : UNMAPPED_IDX_B, $urandom);
      cfg_ch.valid <= 1'b0;
      n = $urandom_range(5, 50);
      repeat (n) send_byte(8'($urandom));
      items += n;
      drain();
    end

    // close any open packet, then one packet at the clamped maximum length and one byte beyond it
    sender_steady = 1'b0;
    write_reg(REG_PAYLOAD_LENGTH, 32'd1);
    cfg_ch.valid <= 1'b0;
    send_byte(8'($urandom));
    drain();
    write_reg(REG_PAYLOAD_LENGTH, 32'd2047);
    cfg_ch.valid <= 1'b0;
    repeat (PAYLOAD_CAP + 1) send_byte(8'($urandom));
    drain();

    // let any stray output show up before the verdict
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
